[rtl/cwe_pkg.sv]
// Shared types, constants and helpers for the clock with error estimate.
package cwe_pkg;

  // Error estimate markers and limits (2^-16 s units)
  localparam logic [31:0] ERR_NEVER      = 32'hFFFF_FFFF;
  localparam logic [31:0] ERR_HIGH       = 32'hFFFF_FFFE;
  localparam logic [31:0] ERR_SAT_LIMIT  = 32'd4294900000;
  localparam logic [31:0] FIVE_MIN_LIMIT = 32'd4275306493;
  localparam logic [31:0] FIVE_MIN_ERR   = 32'd19660800;

  localparam logic [15:0] EPS_RESET   = 16'd2500;
  localparam logic [10:0] MS_PER_SEC  = 11'd1000;
  localparam logic [16:0] FRAC_MUL    = 17'd65;
  localparam logic [16:0] FRAC_OFS    = 17'd32;
  localparam logic [31:0] DELAY_MUL   = 32'd66;
  localparam logic [31:0] MANT_FLOOR  = 32'd255;
  localparam logic [31:0] MANT_MAX    = 32'd255;

  localparam logic signed [7:0] EXP_BIAS    = -8'sd16;
  localparam logic signed [7:0] EXP_SAT     = 8'sd127;
  localparam logic signed [7:0] EXP_IN_MAX  = 8'sd8;
  localparam logic signed [7:0] EXP_IN_MIN  = -8'sd15;
  localparam logic        [7:0] MANT_SAT    = 8'd255;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_SET   = 2'd2,
    ACT_MSG   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DECIDE,
    S_ROLL,
    S_ENC,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;
    logic prep;
    logic decide;
    logic roll;
    logic enc_load;
    logic enc_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ms_ge;
    logic t_gt;
    logic out_free;
  } sts_t;

  // 2^-16 s fraction to elapsed milliseconds
  function automatic logic [9:0] frac_to_ms(input logic [15:0] f);
    return f[15:6] - 10'(f[15:12]) - 10'(f[15:13]);
  endfunction

endpackage

[rtl/cwe_in_if.sv]
// Input item channel.
interface cwe_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [63:0] new_seconds;
  logic        [15:0] new_fraction;
  logic        [31:0] set_error;
  logic signed [7:0]  error_exponent_in;
  logic        [7:0]  error_mantissa_in;
  logic        [15:0] delay_error_ms;
  logic               arrival_accurate;
  logic        [9:0]  arrival_age_ms;

  modport source (
    output valid, action, new_seconds, new_fraction, set_error, error_exponent_in,
           error_mantissa_in, delay_error_ms, arrival_accurate, arrival_age_ms,
    input  ready
  );
  modport sink (
    input  valid, action, new_seconds, new_fraction, set_error, error_exponent_in,
           error_mantissa_in, delay_error_ms, arrival_accurate, arrival_age_ms,
    output ready
  );
endinterface

[rtl/cwe_out_if.sv]
// Result item channel.
interface cwe_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] seconds_out;
  logic        [15:0] fraction_out;
  logic        [31:0] error_out;
  logic signed [7:0]  error_exponent_out;
  logic        [7:0]  error_mantissa_out;
  logic               accepted;

  modport source (
    output valid, seconds_out, fraction_out, error_out, error_exponent_out,
           error_mantissa_out, accepted,
    input  ready
  );
  modport sink (
    input  valid, seconds_out, fraction_out, error_out, error_exponent_out,
           error_mantissa_out, accepted,
    output ready
  );
endinterface

[rtl/cwe_cfg_if.sv]
// Configuration write channel.
interface cwe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] error_per_second;

  modport source (output valid, error_per_second, input ready);
  modport sink   (input valid, error_per_second, output ready);
endinterface

[rtl/cwe_ctrl.sv]
// Sequencer for one item: prepare, decide, roll seconds, encode error, emit.
module cwe_ctrl import cwe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_rdy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_PREP;
      S_PREP:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_ROLL;
      S_ROLL:   if (!sts.ms_ge) state_nxt = S_ENC;
      S_ENC:    if (!sts.t_gt) state_nxt = S_DONE;
      S_DONE:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    in_rdy = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy  = 1'b1;
        cmd.cap = in_valid;
      end
      S_PREP:   cmd.prep = 1'b1;
      S_DECIDE: cmd.decide = 1'b1;
      S_ROLL: begin
        cmd.roll     = sts.ms_ge;
        cmd.enc_load = !sts.ms_ge;
      end
      S_ENC:    cmd.enc_step = sts.t_gt;
      S_DONE:   cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  // accepted beat always starts the prepare step
  a_cap_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_rdy) |=> (state_r == S_PREP))
    else $error("accept did not start prepare");

  // ms count stays below three seconds, so at most two rollovers
  a_roll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROLL && $past(state_r) == S_ROLL && $past(state_r, 2) == S_ROLL)
      |-> !sts.ms_ge)
    else $error("more than two second rollovers");

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("overlapping datapath commands");

endmodule

[rtl/cwe_dp.sv]
// Time, error estimate and result registers with their arithmetic.
module cwe_dp import cwe_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  cwe_in_if.sink        in_bus,
  cwe_out_if.source     out_bus,
  cwe_cfg_if.sink       cfg_bus,
  input  cmd_t          cmd,
  output sts_t          sts
);

  // architectural state
  logic        [15:0] eps_r;
  logic        [63:0] sec_r, sec_nxt;
  logic        [10:0] ms_r, ms_nxt;
  logic        [31:0] est_r, est_nxt;

  // captured item
  action_t            act_r;
  logic        [63:0] nsec_r;
  logic        [15:0] frac_r;
  logic        [31:0] serr_r;
  logic signed [7:0]  exp_r;
  logic        [7:0]  mant_r;
  logic        [15:0] dly_r;
  logic               acc_r;
  logic        [9:0]  age_r;

  // candidate values
  logic        [31:0] cand_r;
  logic        [10:0] ms_cand_r;

  // error encoder
  logic        [31:0] t_r;
  logic signed [7:0]  cnt_r;

  // result register
  logic               out_valid_r;
  logic        [63:0] o_sec_r;
  logic        [15:0] o_frac_r;
  logic        [31:0] o_err_r;
  logic signed [7:0]  o_exp_r;
  logic        [7:0]  o_mant_r;
  logic               o_acc_r;
  logic               take_r;

  logic        [4:0]  shamt;
  logic        [31:0] base_err;
  logic        [31:0] msg_err;
  logic        [31:0] fin_err;
  logic               take;
  logic        [16:0] frac_full;

  assign sts.ms_ge    = (ms_r >= MS_PER_SEC);
  assign sts.t_gt     = (t_r > MANT_MAX);
  assign sts.out_free = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_bus.valid) begin
      eps_r <= cfg_bus.error_per_second;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r  <= action_t'(in_bus.action);
      nsec_r <= in_bus.new_seconds;
      frac_r <= in_bus.new_fraction;
      serr_r <= in_bus.set_error;
      exp_r  <= in_bus.error_exponent_in;
      mant_r <= in_bus.error_mantissa_in;
      dly_r  <= in_bus.delay_error_ms;
      acc_r  <= in_bus.arrival_accurate;
      age_r  <= in_bus.arrival_age_ms;
    end
  end

  // message error before the arrival accuracy term
  always_comb begin
    shamt = 5'(exp_r - EXP_BIAS);
    if (exp_r < EXP_IN_MIN) begin
      base_err = MANT_FLOOR;
    end else begin
      base_err = 32'(mant_r) << shamt;
    end
    msg_err = base_err + 32'(dly_r) * DELAY_MUL;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (act_r == ACT_SET) begin
        cand_r <= serr_r;
      end else if (exp_r > EXP_IN_MAX) begin
        cand_r <= ERR_HIGH;
      end else begin
        cand_r <= msg_err;
      end
      ms_cand_r <= 11'(frac_to_ms(frac_r))
                 + ((act_r == ACT_MSG) ? 11'(age_r) : 11'd0);
    end
  end

  // five-minute term; a saturated candidate stays saturated
  always_comb begin
    fin_err = cand_r;
    if (act_r == ACT_MSG && !acc_r) begin
      fin_err = (cand_r < FIVE_MIN_LIMIT) ? cand_r + FIVE_MIN_ERR : ERR_HIGH;
    end
    take = (act_r == ACT_SET || act_r == ACT_MSG) && (fin_err <= est_r);
  end

  always_comb begin
    sec_nxt = sec_r;
    ms_nxt  = ms_r;
    est_nxt = est_r;
    if (cmd.prep && act_r == ACT_TICK) begin
      ms_nxt = ms_r + 11'd1;
    end else if (cmd.decide && take) begin
      sec_nxt = nsec_r;
      ms_nxt  = ms_cand_r;
      est_nxt = fin_err;
    end else if (cmd.roll) begin
      ms_nxt  = ms_r - MS_PER_SEC;
      sec_nxt = sec_r + 64'd1;
      est_nxt = (est_r < ERR_SAT_LIMIT) ? est_r + 32'(eps_r) : ERR_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= '0;
      ms_r  <= '0;
      est_r <= ERR_NEVER;
    end else begin
      sec_r <= sec_nxt;
      ms_r  <= ms_nxt;
      est_r <= est_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      take_r <= take;
    end
  end

  // normalize the error to an 8-bit mantissa, coarse steps first
  always_ff @(posedge clk) begin
    if (cmd.enc_load) begin
      t_r   <= est_r;
      cnt_r <= EXP_BIAS;
    end else if (cmd.enc_step) begin
      if (t_r[31:16] != '0) begin
        t_r   <= t_r >> 8;
        cnt_r <= cnt_r + 8'sd8;
      end else if (t_r[15:12] != '0) begin
        t_r   <= t_r >> 4;
        cnt_r <= cnt_r + 8'sd4;
      end else if (t_r[15:10] != '0) begin
        t_r   <= t_r >> 2;
        cnt_r <= cnt_r + 8'sd2;
      end else begin
        t_r   <= t_r >> 1;
        cnt_r <= cnt_r + 8'sd1;
      end
    end
  end

  assign frac_full = 17'(ms_r) * FRAC_MUL + 17'(ms_r[10:1]) + FRAC_OFS;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_sec_r  <= sec_r;
      o_frac_r <= frac_full[15:0];
      o_err_r  <= est_r;
      o_acc_r  <= take_r;
      if (est_r >= ERR_HIGH) begin
        o_exp_r  <= EXP_SAT;
        o_mant_r <= MANT_SAT;
      end else begin
        o_exp_r  <= cnt_r;
        o_mant_r <= t_r[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_bus.valid              = out_valid_r;
  assign out_bus.seconds_out        = o_sec_r;
  assign out_bus.fraction_out       = o_frac_r;
  assign out_bus.error_out          = o_err_r;
  assign out_bus.error_exponent_out = o_exp_r;
  assign out_bus.error_mantissa_out = o_mant_r;
  assign out_bus.accepted           = o_acc_r;

  // result is formed only from a normalized time
  a_ms_norm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (ms_r < MS_PER_SEC))
    else $error("result loaded with unnormalized ms");

  // encoder done before the result is formed
  a_enc_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (est_r >= ERR_HIGH || t_r <= MANT_MAX))
    else $error("result loaded before error encoding finished");

  // never overwrite a result that is still waiting
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_bus.ready))
    else $error("pending result overwritten");

endmodule

[rtl/clock_with_error_estimate.sv]
// Top level of the seconds clock with saturating error estimate.
//
// Channels: in_bus takes one item per beat (tick, query, set, time message);
// out_bus returns exactly one result beat per input item, in order, with the
// current time, fraction, error and the error as exponent/mantissa. cfg_bus
// writes error_per_second; it is always ready and is meant to be used only
// while no item is in flight.
// Flow: one item at a time. An item passes the prepare and decide steps,
// r second rollovers and s encoder steps before the result register, with
// r = seconds rolled over (0..2, one per cycle through the 64-bit second
// adder) and s = normalization steps of the error encoder (0..6, one shift
// of 8, 4, 2 or 1 bits per cycle). The next beat is taken only once the
// controller is back in idle, after the result has been loaded.
// Reset (rst_n low, synchronous): time 0, error "never set", error_per_second
// 2500, no result pending, input ready.
// Stall: the result sits in the output register until out_bus.ready; the
// next item is still accepted and worked on, and waits in its final step
// only if the previous result has not been taken yet.
module clock_with_error_estimate import cwe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cwe_in_if.sink    in_bus,
  cwe_out_if.source out_bus,
  cwe_cfg_if.sink   cfg_bus
);

  cmd_t cmd;
  sts_t sts;
  logic in_rdy;

  assign in_bus.ready  = in_rdy;
  assign cfg_bus.ready = 1'b1;

  cwe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_rdy   (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  cwe_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule
